// File: src/zuc_pkg.sv
`timescale 1ns / 1ps

package zuc_pkg;

    localparam logic [30:0] M31 = 31'h7FFF_FFFF;

    localparam logic OP_START = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    localparam logic [1:0] REG_KEY_HIGH = 2'd0;
    localparam logic [1:0] REG_KEY_LOW  = 2'd1;
    localparam logic [1:0] REG_IV_HIGH  = 2'd2;
    localparam logic [1:0] REG_IV_LOW   = 2'd3;

    typedef logic [15:0][30:0] cells_t;

    typedef struct packed {
        cells_t      cells;
        logic [31:0] r1;
        logic [31:0] r2;
        logic [31:0] z;
    } round_out_t;

    typedef struct packed {
        logic [31:0] keystream;
        logic [31:0] data_out;
        logic        unkeyed;
    } result_t;

    localparam logic [14:0] DCONST [16] = '{
        15'h44D7, 15'h26BC, 15'h626B, 15'h135E, 15'h5789, 15'h35E2, 15'h7135, 15'h09AF,
        15'h4D78, 15'h2F13, 15'h6BC4, 15'h1AF1, 15'h5E26, 15'h3C4D, 15'h789A, 15'h47AC
    };

    localparam logic [7:0] SBOX0 [256] = '{
        8'h3e,8'h72,8'h5b,8'h47,8'hca,8'he0,8'h00,8'h33,8'h04,8'hd1,8'h54,8'h98,8'h09,8'hb9,8'h6d,8'hcb,
        8'h7b,8'h1b,8'hf9,8'h32,8'haf,8'h9d,8'h6a,8'ha5,8'hb8,8'h2d,8'hfc,8'h1d,8'h08,8'h53,8'h03,8'h90,
        8'h4d,8'h4e,8'h84,8'h99,8'he4,8'hce,8'hd9,8'h91,8'hdd,8'hb6,8'h85,8'h48,8'h8b,8'h29,8'h6e,8'hac,
        8'hcd,8'hc1,8'hf8,8'h1e,8'h73,8'h43,8'h69,8'hc6,8'hb5,8'hbd,8'hfd,8'h39,8'h63,8'h20,8'hd4,8'h38,
        8'h76,8'h7d,8'hb2,8'ha7,8'hcf,8'hed,8'h57,8'hc5,8'hf3,8'h2c,8'hbb,8'h14,8'h21,8'h06,8'h55,8'h9b,
        8'he3,8'hef,8'h5e,8'h31,8'h4f,8'h7f,8'h5a,8'ha4,8'h0d,8'h82,8'h51,8'h49,8'h5f,8'hba,8'h58,8'h1c,
        8'h4a,8'h16,8'hd5,8'h17,8'ha8,8'h92,8'h24,8'h1f,8'h8c,8'hff,8'hd8,8'hae,8'h2e,8'h01,8'hd3,8'had,
        8'h3b,8'h4b,8'hda,8'h46,8'heb,8'hc9,8'hde,8'h9a,8'h8f,8'h87,8'hd7,8'h3a,8'h80,8'h6f,8'h2f,8'hc8,
        8'hb1,8'hb4,8'h37,8'hf7,8'h0a,8'h22,8'h13,8'h28,8'h7c,8'hcc,8'h3c,8'h89,8'hc7,8'hc3,8'h96,8'h56,
        8'h07,8'hbf,8'h7e,8'hf0,8'h0b,8'h2b,8'h97,8'h52,8'h35,8'h41,8'h79,8'h61,8'ha6,8'h4c,8'h10,8'hfe,
        8'hbc,8'h26,8'h95,8'h88,8'h8a,8'hb0,8'ha3,8'hfb,8'hc0,8'h18,8'h94,8'hf2,8'he1,8'he5,8'he9,8'h5d,
        8'hd0,8'hdc,8'h11,8'h66,8'h64,8'h5c,8'hec,8'h59,8'h42,8'h75,8'h12,8'hf5,8'h74,8'h9c,8'haa,8'h23,
        8'h0e,8'h86,8'hab,8'hbe,8'h2a,8'h02,8'he7,8'h67,8'he6,8'h44,8'ha2,8'h6c,8'hc2,8'h93,8'h9f,8'hf1,
        8'hf6,8'hfa,8'h36,8'hd2,8'h50,8'h68,8'h9e,8'h62,8'h71,8'h15,8'h3d,8'hd6,8'h40,8'hc4,8'he2,8'h0f,
        8'h8e,8'h83,8'h77,8'h6b,8'h25,8'h05,8'h3f,8'h0c,8'h30,8'hea,8'h70,8'hb7,8'ha1,8'he8,8'ha9,8'h65,
        8'h8d,8'h27,8'h1a,8'hdb,8'h81,8'hb3,8'ha0,8'hf4,8'h45,8'h7a,8'h19,8'hdf,8'hee,8'h78,8'h34,8'h60
    };

    localparam logic [7:0] SBOX1 [256] = '{
        8'h55,8'hc2,8'h63,8'h71,8'h3b,8'hc8,8'h47,8'h86,8'h9f,8'h3c,8'hda,8'h5b,8'h29,8'haa,8'hfd,8'h77,
        8'h8c,8'hc5,8'h94,8'h0c,8'ha6,8'h1a,8'h13,8'h00,8'he3,8'ha8,8'h16,8'h72,8'h40,8'hf9,8'hf8,8'h42,
        8'h44,8'h26,8'h68,8'h96,8'h81,8'hd9,8'h45,8'h3e,8'h10,8'h76,8'hc6,8'ha7,8'h8b,8'h39,8'h43,8'he1,
        8'h3a,8'hb5,8'h56,8'h2a,8'hc0,8'h6d,8'hb3,8'h05,8'h22,8'h66,8'hbf,8'hdc,8'h0b,8'hfa,8'h62,8'h48,
        8'hdd,8'h20,8'h11,8'h06,8'h36,8'hc9,8'hc1,8'hcf,8'hf6,8'h27,8'h52,8'hbb,8'h69,8'hf5,8'hd4,8'h87,
        8'h7f,8'h84,8'h4c,8'hd2,8'h9c,8'h57,8'ha4,8'hbc,8'h4f,8'h9a,8'hdf,8'hfe,8'hd6,8'h8d,8'h7a,8'heb,
        8'h2b,8'h53,8'hd8,8'h5c,8'ha1,8'h14,8'h17,8'hfb,8'h23,8'hd5,8'h7d,8'h30,8'h67,8'h73,8'h08,8'h09,
        8'hee,8'hb7,8'h70,8'h3f,8'h61,8'hb2,8'h19,8'h8e,8'h4e,8'he5,8'h4b,8'h93,8'h8f,8'h5d,8'hdb,8'ha9,
        8'had,8'hf1,8'hae,8'h2e,8'hcb,8'h0d,8'hfc,8'hf4,8'h2d,8'h46,8'h6e,8'h1d,8'h97,8'he8,8'hd1,8'he9,
        8'h4d,8'h37,8'ha5,8'h75,8'h5e,8'h83,8'h9e,8'hab,8'h82,8'h9d,8'hb9,8'h1c,8'he0,8'hcd,8'h49,8'h89,
        8'h01,8'hb6,8'hbd,8'h58,8'h24,8'ha2,8'h5f,8'h38,8'h78,8'h99,8'h15,8'h90,8'h50,8'hb8,8'h95,8'he4,
        8'hd0,8'h91,8'hc7,8'hce,8'hed,8'h0f,8'hb4,8'h6f,8'ha0,8'hcc,8'hf0,8'h02,8'h4a,8'h79,8'hc3,8'hde,
        8'ha3,8'hef,8'hea,8'h51,8'he6,8'h6b,8'h18,8'hec,8'h1b,8'h2c,8'h80,8'hf7,8'h74,8'he7,8'hff,8'h21,
        8'h5a,8'h6a,8'h54,8'h1e,8'h41,8'h31,8'h92,8'h35,8'hc4,8'h33,8'h07,8'h0a,8'hba,8'h7e,8'h0e,8'h34,
        8'h88,8'hb1,8'h98,8'h7c,8'hf3,8'h3d,8'h60,8'h6c,8'h7b,8'hca,8'hd3,8'h1f,8'h32,8'h65,8'h04,8'h28,
        8'h64,8'hbe,8'h85,8'h9b,8'h2f,8'h59,8'h8a,8'hd7,8'hb0,8'h25,8'hac,8'haf,8'h12,8'h03,8'he2,8'hf2
    };

    function automatic logic [30:0] add31(input logic [30:0] a, input logic [30:0] b);
        logic [31:0] c;
        c = {1'b0, a} + {1'b0, b};
        return c[30:0] + 31'(c[31]);
    endfunction

    function automatic logic [30:0] rot31(input logic [30:0] x, input int k);
        return (x << k) | (x >> (31 - k));
    endfunction

    function automatic logic [31:0] rot32(input logic [31:0] x, input int k);
        return (x << k) | (x >> (32 - k));
    endfunction

    function automatic logic [31:0] lin1(input logic [31:0] x);
        return x ^ rot32(x, 2) ^ rot32(x, 10) ^ rot32(x, 18) ^ rot32(x, 24);
    endfunction

    function automatic logic [31:0] lin2(input logic [31:0] x);
        return x ^ rot32(x, 8) ^ rot32(x, 14) ^ rot32(x, 22) ^ rot32(x, 30);
    endfunction

    function automatic logic [31:0] subst(input logic [31:0] x);
        return {SBOX0[x[31:24]], SBOX1[x[23:16]], SBOX0[x[15:8]], SBOX1[x[7:0]]};
    endfunction

endpackage

// File: src/zuc_round.sv
`timescale 1ns / 1ps

module zuc_round (
    input  zuc_pkg::cells_t     cells,
    input  logic [31:0]         r1,
    input  logic [31:0]         r2,
    input  logic                init_mode,
    output zuc_pkg::round_out_t round_out
);

    logic [31:0] x0;
    logic [31:0] x1;
    logic [31:0] x2;
    logic [31:0] x3;
    logic [31:0] w;
    logic [31:0] w1;
    logic [31:0] w2;
    logic [30:0] fb;

    // bit reorganization
    assign x0 = {cells[15][30:15], cells[14][15:0]};
    assign x1 = {cells[11][15:0], cells[9][30:15]};
    assign x2 = {cells[7][15:0], cells[5][30:15]};
    assign x3 = {cells[2][15:0], cells[0][30:15]};

    // nonlinear function
    assign w  = (x0 ^ r1) + r2;
    assign w1 = r1 + x1;
    assign w2 = r2 ^ x2;

    always_comb begin
        fb = zuc_pkg::add31(cells[0], zuc_pkg::rot31(cells[0], 8));
        fb = zuc_pkg::add31(fb, zuc_pkg::rot31(cells[4], 20));
        fb = zuc_pkg::add31(fb, zuc_pkg::rot31(cells[10], 21));
        fb = zuc_pkg::add31(fb, zuc_pkg::rot31(cells[13], 17));
        fb = zuc_pkg::add31(fb, zuc_pkg::rot31(cells[15], 15));
        if (init_mode) begin
            fb = zuc_pkg::add31(fb, w[31:1]);
        end
        if (fb == '0) begin
            fb = zuc_pkg::M31;
        end
    end

    always_comb begin
        for (int i = 0; i < 15; i++) begin
            round_out.cells[i] = cells[i + 1];
        end
        round_out.cells[15] = fb;
        round_out.r1 = zuc_pkg::subst(zuc_pkg::lin1({w1[15:0], w2[31:16]}));
        round_out.r2 = zuc_pkg::subst(zuc_pkg::lin2({w2[15:0], w1[31:16]}));
        round_out.z  = w ^ x3;
    end

endmodule

// File: src/zuc_obuf.sv
`timescale 1ns / 1ps

module zuc_obuf (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  zuc_pkg::result_t     push_data,
    output logic                 full,
    output logic                 m_valid,
    input  logic                 m_ready,
    output zuc_pkg::result_t     m_data
);

    logic             main_valid_reg;
    logic             main_valid_next;
    zuc_pkg::result_t main_data_reg;
    zuc_pkg::result_t main_data_next;
    logic             skid_valid_reg;
    logic             skid_valid_next;
    zuc_pkg::result_t skid_data_reg;
    zuc_pkg::result_t skid_data_next;

    always_comb begin
        main_valid_next = main_valid_reg;
        main_data_next  = main_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (m_ready || !main_valid_reg) begin
            if (skid_valid_reg) begin
                main_valid_next = 1'b1;
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                main_valid_next = push;
                main_data_next  = push_data;
            end
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full    = skid_valid_reg;
    assign m_valid = main_valid_reg;
    assign m_data  = main_data_reg;

`ifndef SYNTHESIS
    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held with empty output register");
`endif

endmodule

// File: src/zuc_keystream_cipher_core.sv
`timescale 1ns / 1ps

// zuc-128 keystream engine
// config: cfg_wr_en/cfg_index/cfg_wdata write key_high, key_low, iv_high, iv_low
//   (index 0..3); write only while the engine is idle
// input transaction (s_valid/s_ready): s_op = 0 starts a session from key and iv,
//   s_op = 1 encrypts or decrypts the 32-bit word s_data_in
// a start occupies the round logic for its initialization rounds;
//   s_ready is low during that time and the start gives no result
// a data transaction's result (m_keystream, m_data_out, m_unkeyed) is
//   registered and, unless the receiver stalls, shows on m_valid the cycle
//   after acceptance; a data word can be accepted every cycle s_ready is high
// m_unkeyed is 1 for words sent before any start since reset
// a two-entry output buffer decouples the sides: when the receiver stalls one
//   more word is taken, then s_ready drops until m_ready returns
// reset (aresetn low, synchronous) clears key, iv, lfsr cells, r1, r2, the
//   keyed flag and the output buffer
module zuc_keystream_cipher_core #(
    parameter int INIT_ROUNDS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [31:0] s_data_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_keystream,
    output logic [31:0] m_data_out,
    output logic        m_unkeyed
);

    localparam int CNT_W = $clog2(INIT_ROUNDS + 1);
    localparam logic [CNT_W-1:0] LAST_ROUND = CNT_W'(INIT_ROUNDS);

    logic [63:0]         key_high_reg;
    logic [63:0]         key_low_reg;
    logic [63:0]         iv_high_reg;
    logic [63:0]         iv_low_reg;
    zuc_pkg::cells_t     cells_reg;
    zuc_pkg::cells_t     cells_next;
    logic [31:0]         r1_reg;
    logic [31:0]         r1_next;
    logic [31:0]         r2_reg;
    logic [31:0]         r2_next;
    logic                keyed_reg;
    logic                keyed_next;
    logic                busy_reg;
    logic                busy_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;

    zuc_pkg::cells_t     load_cells;
    zuc_pkg::round_out_t rnd;
    zuc_pkg::result_t    result;
    zuc_pkg::result_t    m_result;
    logic                init_mode;
    logic                obuf_full;
    logic                start_acc;
    logic                data_acc;

    assign s_ready   = !busy_reg && !obuf_full;
    assign start_acc = s_valid && s_ready && (s_op == zuc_pkg::OP_START);
    assign data_acc  = s_valid && s_ready && (s_op == zuc_pkg::OP_DATA);
    assign init_mode = busy_reg && (count_reg != LAST_ROUND);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            iv_high_reg  <= '0;
            iv_low_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                zuc_pkg::REG_KEY_HIGH: key_high_reg <= cfg_wdata;
                zuc_pkg::REG_KEY_LOW:  key_low_reg  <= cfg_wdata;
                zuc_pkg::REG_IV_HIGH:  iv_high_reg  <= cfg_wdata;
                zuc_pkg::REG_IV_LOW:   iv_low_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            load_cells[i] = {key_high_reg[63 - 8*i -: 8], zuc_pkg::DCONST[i],
                             iv_high_reg[63 - 8*i -: 8]};
            load_cells[i + 8] = {key_low_reg[63 - 8*i -: 8], zuc_pkg::DCONST[i + 8],
                                 iv_low_reg[63 - 8*i -: 8]};
        end
    end

    zuc_round u_round (
        .cells     (cells_reg),
        .r1        (r1_reg),
        .r2        (r2_reg),
        .init_mode (init_mode),
        .round_out (rnd)
    );

    always_comb begin
        cells_next = cells_reg;
        r1_next    = r1_reg;
        r2_next    = r2_reg;
        keyed_next = keyed_reg;
        busy_next  = busy_reg;
        count_next = count_reg;
        if (busy_reg) begin
            cells_next = rnd.cells;
            r1_next    = rnd.r1;
            r2_next    = rnd.r2;
            count_next = count_reg + 1'b1;
            if (count_reg == LAST_ROUND) begin
                busy_next  = 1'b0;
                keyed_next = 1'b1;
            end
        end else if (start_acc) begin
            cells_next = load_cells;
            r1_next    = '0;
            r2_next    = '0;
            busy_next  = 1'b1;
            count_next = '0;
        end else if (data_acc) begin
            cells_next = rnd.cells;
            r1_next    = rnd.r1;
            r2_next    = rnd.r2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cells_reg <= '0;
            r1_reg    <= '0;
            r2_reg    <= '0;
            keyed_reg <= 1'b0;
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            cells_reg <= cells_next;
            r1_reg    <= r1_next;
            r2_reg    <= r2_next;
            keyed_reg <= keyed_next;
            busy_reg  <= busy_next;
            count_reg <= count_next;
        end
    end

    assign result.keystream = rnd.z;
    assign result.data_out  = s_data_in ^ rnd.z;
    assign result.unkeyed   = !keyed_reg;

    zuc_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (data_acc),
        .push_data (result),
        .full      (obuf_full),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_result)
    );

    assign m_keystream = m_result.keystream;
    assign m_data_out  = m_result.data_out;
    assign m_unkeyed   = m_result.unkeyed;

`ifndef SYNTHESIS
    a_start_begins_rounds: assert property (@(posedge aclk) disable iff (!aresetn)
        start_acc |=> busy_reg && (count_reg == '0))
        else $error("start transaction did not begin key setup");

    a_setup_ends_keyed: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && (count_reg == LAST_ROUND)) |=> (!busy_reg && keyed_reg))
        else $error("key setup did not finish after the last round");

    a_data_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        data_acc |=> m_valid)
        else $error("data transaction produced no result");

    a_no_result_during_setup: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !data_acc && !start_acc)
        else $error("transaction accepted during key setup");
`endif

endmodule
